>>> hdl/dasp_pkg.sv
// Shared types, register indexes and constants for the DV audio shuffle packer.
package dasp_pkg;

  localparam int IDX_W  = 11;
  localparam int ADDR_W = 18;

  typedef struct packed {
    logic             req_type;
    logic [IDX_W-1:0] sample_index;
    logic [15:0]      sample_a;
    logic [15:0]      sample_b;
    logic [15:0]      sample_c;
    logic [15:0]      sample_d;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [7:0]        byte_first;
    logic [7:0]        byte_second;
    logic [7:0]        byte_third;
    logic [1:0]        byte_count;
    logic              last_write;
  } out_item_t;

  typedef struct packed {
    logic [7:0] b_first;
    logic [7:0] b_second;
    logic [7:0] b_third;
  } grp_bytes_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr0;
    logic [ADDR_W-1:0] addr1;
    grp_bytes_t        bytes0;
    grp_bytes_t        bytes1;
    logic              twelve;
  } loc_t;

  localparam logic [1:0] CFG_PAL_MODE   = 2'd0;
  localparam logic [1:0] CFG_TWELVE_BIT = 2'd1;
  localparam logic [1:0] CFG_BIG_ENDIAN = 2'd2;

  localparam logic REQ_CLEAR = 1'b1;

  localparam logic [1:0] CNT_16BIT = 2'd2;
  localparam logic [1:0] CNT_12BIT = 2'd3;

  localparam logic [7:0] SILENCE_HI = 8'h80;

  localparam logic [ADDR_W-1:0] SEQ_BYTES    = 18'd12000;
  localparam logic [13:0]       BLOCK_HEADER = 14'd3;
  localparam logic [7:0]        AAUX_BYTES   = 8'd5;

  // frame capacity in samples per group
  localparam logic [IDX_W-1:0] CAP_NTSC_16 = 11'd1620;
  localparam logic [IDX_W-1:0] CAP_PAL_16  = 11'd1944;
  localparam logic [IDX_W-1:0] CAP_NTSC_12 = 11'd1080;
  localparam logic [IDX_W-1:0] CAP_PAL_12  = 11'd1296;

  localparam logic [5:0] PERIOD_NTSC = 6'd45;
  localparam logic [5:0] PERIOD_PAL  = 6'd54;
  localparam logic [5:0] THIRD_NTSC  = 6'd15;
  localparam logic [5:0] THIRD_PAL   = 6'd18;
  localparam logic [2:0] TRACKS_NTSC = 3'd5;
  localparam logic [2:0] TRACKS_PAL  = 3'd6;

  // reciprocals: n/3 = n*683>>11, n/45 = n*1457>>16, n/54 = n*1214>>16
  localparam logic [20:0] RECIP_3      = 21'd683;
  localparam logic [21:0] RECIP_NTSC_P = 22'd1457;
  localparam logic [21:0] RECIP_PAL_P  = 22'd1214;
  // v/5 = v*205>>10, v/6 = v*683>>12
  localparam logic [18:0] RECIP_5 = 19'd205;
  localparam logic [18:0] RECIP_6 = 19'd683;

  function automatic logic [ADDR_W-1:0] seq_offset(input logic [3:0] s);
    seq_offset = ADDR_W'(s) * SEQ_BYTES;
  endfunction

endpackage

>>> hdl/dasp_compress.sv
// Piecewise 16-to-12 bit nonlinear sample compression.
module dasp_compress (
  input  logic [15:0] s,
  output logic [11:0] c
);
  logic [15:0] r;

  always_comb begin
    priority if (s >= 16'hfe00) begin
      r = s - 16'hf000;
    end else if (s >= 16'hfc00) begin
      r = (s >> 1) - 16'h7100;
    end else if (s >= 16'hf800) begin
      r = (s >> 2) - 16'h3200;
    end else if (s >= 16'hf000) begin
      r = (s >> 3) - 16'h1300;
    end else if (s >= 16'he000) begin
      r = (s >> 4) - 16'h0400;
    end else if (s >= 16'hc000) begin
      r = (s >> 5) + 16'h0300;
    end else if (s >= 16'h4000) begin
      r = (s >> 6) + 16'h0600;
    end else if (s >= 16'h2000) begin
      r = (s >> 5) + 16'h0500;
    end else if (s >= 16'h1000) begin
      r = (s >> 4) + 16'h0400;
    end else if (s >= 16'h0800) begin
      r = (s >> 3) + 16'h0300;
    end else if (s >= 16'h0400) begin
      r = (s >> 2) + 16'h0200;
    end else begin
      r = (s >> 1) + 16'h0100;
    end
  end

  assign c = r[11:0];

endmodule

>>> hdl/dasp_fmt.sv
// Byte formatting of one channel group: swap, compress, pack or silence.
module dasp_fmt (
  input  logic                   clear,
  input  logic                   twelve,
  input  logic                   swap,
  input  logic [15:0]            w0,
  input  logic [15:0]            w1,
  output dasp_pkg::grp_bytes_t   bytes
);
  import dasp_pkg::*;

  logic [15:0] s0;
  logic [15:0] s1;
  logic [11:0] x;
  logic [11:0] y;

  assign s0 = swap ? {w0[7:0], w0[15:8]} : w0;
  assign s1 = swap ? {w1[7:0], w1[15:8]} : w1;

  dasp_compress u_cmp_x (.s(s0), .c(x));
  dasp_compress u_cmp_y (.s(s1), .c(y));

  always_comb begin
    if (clear) begin
      bytes.b_first  = SILENCE_HI;
      bytes.b_second = twelve ? SILENCE_HI : 8'h00;
      bytes.b_third  = 8'h00;
    end else if (twelve) begin
      bytes.b_first  = x[11:4];
      bytes.b_second = y[11:4];
      bytes.b_third  = {x[3:0], y[3:0]};
    end else begin
      bytes.b_first  = s0[15:8];
      bytes.b_second = s0[7:0];
      bytes.b_third  = 8'h00;
    end
  end

endmodule

>>> hdl/dasp_locate.sv
// Three-stage shuffle address pipeline: divide, place in sync block, reduce by track count.
module dasp_locate (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pal_mode,
  input  logic                          twelve_bit_mode,
  input  logic                          in_vld,
  output logic                          in_rdy,
  input  logic [dasp_pkg::IDX_W-1:0]    idx,
  input  dasp_pkg::grp_bytes_t          bytes0_in,
  input  dasp_pkg::grp_bytes_t          bytes1_in,
  output logic                          out_vld,
  input  logic                          out_rdy,
  output dasp_pkg::loc_t                loc
);
  import dasp_pkg::*;

  logic adv_b;
  logic adv_c;
  logic adv_d;

  // stage B
  logic             b_vld_r, b_vld_nxt;
  logic [IDX_W-1:0] b_n_r;
  logic [9:0]       b_q3_r;
  logic [5:0]       b_qp_r;
  grp_bytes_t       b_by0_r, b_by1_r;
  logic [20:0]      q3_prod;
  logic [21:0]      qp_prod;
  logic [IDX_W-1:0] cap;
  logic             in_range;

  // stage C
  logic        c_vld_r, c_vld_nxt;
  logic [9:0]  c_v_r;
  logic [13:0] c_lo_r;
  grp_bytes_t  c_by0_r, c_by1_r;
  logic [IDX_W-1:0] q3x3;
  logic [IDX_W-1:0] r3_full;
  logic [1:0]  r3;
  logic [11:0] pq;
  logic [IDX_W-1:0] rp_full;
  logic [5:0]  rp;
  logic [5:0]  third;
  logic [1:0]  kseg;
  logic [3:0]  sidx;
  logic [7:0]  blk;
  logic [7:0]  off;
  logic [9:0]  v;
  logic [13:0] lo;

  // stage D
  logic        d_vld_r, d_vld_nxt;
  logic [9:0]  d_v_r;
  logic [7:0]  d_qt_r;
  logic [13:0] d_lo_r;
  grp_bytes_t  d_by0_r, d_by1_r;
  logic [18:0] qt_prod;
  logic [7:0]  qt;
  logic [2:0]  tracks;
  logic [10:0] tq;
  logic [10:0] seq_full;
  logic [3:0]  seq;

  assign adv_d  = !d_vld_r || out_rdy;
  assign adv_c  = !c_vld_r || adv_d;
  assign adv_b  = !b_vld_r || adv_c;
  assign in_rdy = adv_b;

  // stage B: quotients by 3 and by the period
  always_comb begin
    unique case ({pal_mode, twelve_bit_mode})
      2'b00:   cap = CAP_NTSC_16;
      2'b10:   cap = CAP_PAL_16;
      2'b01:   cap = CAP_NTSC_12;
      default: cap = CAP_PAL_12;
    endcase
  end

  assign in_range = idx < cap;
  assign q3_prod  = 21'(idx) * RECIP_3;
  assign qp_prod  = 22'(idx) * (pal_mode ? RECIP_PAL_P : RECIP_NTSC_P);
  assign b_vld_nxt = adv_b ? (in_vld && in_range) : b_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= b_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b && in_vld) begin
      b_n_r   <= idx;
      b_q3_r  <= q3_prod[20:11];
      b_qp_r  <= qp_prod[21:16];
      b_by0_r <= bytes0_in;
      b_by1_r <= bytes1_in;
    end
  end

  // stage C: remainders, sync block and in-block offset
  assign q3x3    = IDX_W'({b_q3_r, 1'b0}) + IDX_W'(b_q3_r);
  assign r3_full = b_n_r - q3x3;
  assign r3      = r3_full[1:0];
  assign pq      = 12'(b_qp_r) * 12'(pal_mode ? PERIOD_PAL : PERIOD_NTSC);
  assign rp_full = b_n_r - pq[IDX_W-1:0];
  assign rp      = rp_full[5:0];
  assign third   = pal_mode ? THIRD_PAL : THIRD_NTSC;
  assign v       = b_q3_r + 10'({r3, 1'b0});

  always_comb begin
    priority if (rp >= 6'({third, 1'b0})) begin
      kseg = 2'd2;
    end else if (rp >= third) begin
      kseg = 2'd1;
    end else begin
      kseg = 2'd0;
    end
  end

  assign sidx = 4'({r3, 1'b0}) + 4'(r3) + 4'(kseg);
  assign blk  = {sidx, 4'b0000} + 8'd6;
  assign off  = AAUX_BYTES + (twelve_bit_mode ? (8'({b_qp_r, 1'b0}) + 8'(b_qp_r))
                                              : 8'({b_qp_r, 1'b0}));
  assign lo   = 14'({blk, 6'b000000}) + 14'({blk, 4'b0000}) + BLOCK_HEADER + 14'(off);
  assign c_vld_nxt = adv_c ? b_vld_r : c_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= c_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c && b_vld_r) begin
      c_v_r   <= v;
      c_lo_r  <= lo;
      c_by0_r <= b_by0_r;
      c_by1_r <= b_by1_r;
    end
  end

  // stage D: quotient by track count
  assign qt_prod = 19'(c_v_r) * (pal_mode ? RECIP_6 : RECIP_5);
  assign qt      = pal_mode ? 8'(qt_prod[18:12]) : qt_prod[17:10];
  assign d_vld_nxt = adv_d ? c_vld_r : d_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= d_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_d && c_vld_r) begin
      d_v_r   <= c_v_r;
      d_qt_r  <= qt;
      d_lo_r  <= c_lo_r;
      d_by0_r <= c_by0_r;
      d_by1_r <= c_by1_r;
    end
  end

  // sequence and final frame addresses for both groups
  assign tracks   = pal_mode ? TRACKS_PAL : TRACKS_NTSC;
  assign tq       = 11'(d_qt_r) * 11'(tracks);
  assign seq_full = 11'(d_v_r) - tq;
  assign seq      = 4'(seq_full[2:0]);

  assign out_vld     = d_vld_r;
  assign loc.addr0   = seq_offset(seq) + ADDR_W'(d_lo_r);
  assign loc.addr1   = seq_offset(seq + 4'(tracks)) + ADDR_W'(d_lo_r);
  assign loc.bytes0  = d_by0_r;
  assign loc.bytes1  = d_by1_r;
  assign loc.twelve  = twelve_bit_mode;

endmodule

>>> hdl/dasp_out.sv
// Result register that issues the two group writes of one item as two beats.
module dasp_out (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  output logic                 in_rdy,
  input  dasp_pkg::loc_t       loc,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dasp_pkg::out_item_t  out_item
);
  import dasp_pkg::*;

  logic vld_r, vld_nxt;
  logic grp_r, grp_nxt;
  loc_t loc_r;

  assign in_rdy = !vld_r || (out_ready && grp_r);

  always_comb begin
    vld_nxt = vld_r;
    grp_nxt = grp_r;
    if (in_rdy) begin
      vld_nxt = in_vld;
      grp_nxt = 1'b0;
    end else if (out_ready) begin
      grp_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      grp_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      grp_r <= grp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      loc_r <= loc;
    end
  end

  assign out_valid              = vld_r;
  assign out_item.write_address = grp_r ? loc_r.addr1 : loc_r.addr0;
  assign out_item.byte_first    = grp_r ? loc_r.bytes1.b_first : loc_r.bytes0.b_first;
  assign out_item.byte_second   = grp_r ? loc_r.bytes1.b_second : loc_r.bytes0.b_second;
  assign out_item.byte_third    = grp_r ? loc_r.bytes1.b_third : loc_r.bytes0.b_third;
  assign out_item.byte_count    = loc_r.twelve ? CNT_12BIT : CNT_16BIT;
  assign out_item.last_write    = grp_r;

endmodule

>>> hdl/dv_audio_sample_shuffle_packer.sv
// Top level of the DV audio sample shuffle packer.
// The first result beat passes the input register, stages B, C, D and the result register;
// the second (last_write) beat follows in the next cycle when out_ready is held high.
// Both writes share one result register, so a new item enters only as last_write leaves.
// Indexes beyond the frame capacity are dropped after the input register and give no beat.
// Synchronous active-low reset clears all valid flags and the three mode registers.
module dv_audio_sample_shuffle_packer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [0:0]           cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dasp_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dasp_pkg::out_item_t  out_item
);
  import dasp_pkg::*;

  logic pal_mode_r, twelve_bit_r, big_endian_r;
  logic a_vld_r, a_vld_nxt;
  in_item_t a_item_r;
  logic clear;
  logic [15:0] g1_w0;
  grp_bytes_t bytes0, bytes1;
  logic loc_rdy;
  logic loc_vld;
  logic out_rdy_int;
  loc_t loc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_mode_r   <= 1'b0;
      twelve_bit_r <= 1'b0;
      big_endian_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAL_MODE:   pal_mode_r   <= cfg_wdata[0];
        CFG_TWELVE_BIT: twelve_bit_r <= cfg_wdata[0];
        CFG_BIG_ENDIAN: big_endian_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input register
  assign in_ready  = !a_vld_r || loc_rdy;
  assign a_vld_nxt = in_ready ? in_valid : a_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_item_r <= in_item;
    end
  end

  assign clear = a_item_r.req_type == REQ_CLEAR;
  assign g1_w0 = twelve_bit_r ? a_item_r.sample_c : a_item_r.sample_b;

  dasp_fmt u_fmt0 (
    .clear  (clear),
    .twelve (twelve_bit_r),
    .swap   (big_endian_r),
    .w0     (a_item_r.sample_a),
    .w1     (a_item_r.sample_b),
    .bytes  (bytes0)
  );

  dasp_fmt u_fmt1 (
    .clear  (clear),
    .twelve (twelve_bit_r),
    .swap   (big_endian_r),
    .w0     (g1_w0),
    .w1     (a_item_r.sample_d),
    .bytes  (bytes1)
  );

  dasp_locate u_locate (
    .clk             (clk),
    .rst_n           (rst_n),
    .pal_mode        (pal_mode_r),
    .twelve_bit_mode (twelve_bit_r),
    .in_vld          (a_vld_r),
    .in_rdy          (loc_rdy),
    .idx             (a_item_r.sample_index),
    .bytes0_in       (bytes0),
    .bytes1_in       (bytes1),
    .out_vld         (loc_vld),
    .out_rdy         (out_rdy_int),
    .loc             (loc)
  );

  dasp_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (loc_vld),
    .in_rdy    (out_rdy_int),
    .loc       (loc),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

>>> sim/dasp_checker.sv
// Watches the sample and frame-write channels, predicts each frame write and compares.
`timescale 1ns / 100ps
module dasp_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [0:0]          cfg_wdata,
  input  logic                in_valid,
  input  logic                in_ready,
  input  dasp_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  dasp_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending
);
  import dasp_pkg::*;

  localparam int unsigned FRAME_SEQ_BYTES = 12000;
  localparam int unsigned DIF_BLOCK_BYTES = 80;
  localparam int unsigned DIF_ID_BYTES    = 3;
  localparam int unsigned AAUX_PACK_BYTES = 5;
  localparam int          MAX_PRINTED     = 100;

  logic pal_layout;
  logic packed_12bit;
  logic swap_bytes;
  out_item_t frame_writes_q[$];
  int unsigned beat_no;

  function automatic logic [15:0] order_word(input logic [15:0] w);
    return swap_bytes ? {w[7:0], w[15:8]} : w;
  endfunction

  function automatic logic [11:0] compress_12bit(input logic [15:0] s);
    int unsigned v;
    int unsigned r;
    v = s;
    if (v >= 'hfe00)      r = v - 'hf000;
    else if (v >= 'hfc00) r = (v >> 1) - 'h7100;
    else if (v >= 'hf800) r = (v >> 2) - 'h3200;
    else if (v >= 'hf000) r = (v >> 3) - 'h1300;
    else if (v >= 'he000) r = (v >> 4) - 'h400;
    else if (v >= 'hc000) r = (v >> 5) + 'h300;
    else if (v >= 'h4000) r = (v >> 6) + 'h600;
    else if (v >= 'h2000) r = (v >> 5) + 'h500;
    else if (v >= 'h1000) r = (v >> 4) + 'h400;
    else if (v >= 'h800)  r = (v >> 3) + 'h300;
    else if (v >= 'h400)  r = (v >> 2) + 'h200;
    else                  r = (v >> 1) + 'h100;
    return r[11:0];
  endfunction

  task automatic place_in_frame(input in_item_t it);
    int unsigned n, tracks, period, per_block, word_bytes;
    int unsigned seq, sync_blk, dif_blk, offset, base, group_stride;
    logic [15:0] words [4];
    logic [15:0] w;
    logic [11:0] x, y;
    out_item_t wr;
    n          = it.sample_index;
    tracks     = pal_layout ? 6 : 5;
    period     = pal_layout ? 54 : 45;
    per_block  = packed_12bit ? 24 : 36;
    word_bytes = packed_12bit ? 3 : 2;
    words[0] = it.sample_a;
    words[1] = it.sample_b;
    words[2] = it.sample_c;
    words[3] = it.sample_d;
    // drop indexes past the frame capacity
    if (n >= period * per_block) return;
    seq          = (n / 3 + 2 * (n % 3)) % tracks;
    sync_blk     = 2 + 3 * (n % 3) + (n % period) / (period / 3);
    dif_blk      = 6 + (sync_blk - 2) * 16;
    offset       = AAUX_PACK_BYTES + word_bytes * (n / period);
    base         = seq * FRAME_SEQ_BYTES + dif_blk * DIF_BLOCK_BYTES + DIF_ID_BYTES + offset;
    group_stride = tracks * FRAME_SEQ_BYTES;
    for (int g = 0; g < 2; g++) begin
      wr = '0;
      wr.write_address = ADDR_W'(base + g * group_stride);
      wr.byte_count    = packed_12bit ? CNT_12BIT : CNT_16BIT;
      wr.last_write    = (g == 1);
      if (it.req_type == REQ_CLEAR) begin
        wr.byte_first  = SILENCE_HI;
        wr.byte_second = packed_12bit ? SILENCE_HI : 8'h00;
      end else if (packed_12bit) begin
        x = compress_12bit(order_word(words[2 * g]));
        y = compress_12bit(order_word(words[2 * g + 1]));
        wr.byte_first  = x[11:4];
        wr.byte_second = y[11:4];
        wr.byte_third  = {x[3:0], y[3:0]};
      end else begin
        w = order_word(words[g]);
        wr.byte_first  = w[15:8];
        wr.byte_second = w[7:0];
      end
      frame_writes_q.push_back(wr);
    end
  endtask

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_PRINTED)
      $display("%0t ns: write beat %0d: %s", $time, beat_no, what);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pal_layout   = 1'b0;
      packed_12bit = 1'b0;
      swap_bytes   = 1'b0;
      fail_count   = 0;
      beat_no      = 0;
      frame_writes_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PAL_MODE:   pal_layout   = cfg_wdata[0];
          CFG_TWELVE_BIT: packed_12bit = cfg_wdata[0];
          CFG_BIG_ENDIAN: swap_bytes   = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (frame_writes_q.size() == 0) begin
          report_mismatch("write with none expected");
        end else begin
          out_item_t want;
          want = frame_writes_q.pop_front();
          compare_field("write_address", 32'(out_item.write_address), 32'(want.write_address));
          compare_field("byte_first", 32'(out_item.byte_first), 32'(want.byte_first));
          compare_field("byte_second", 32'(out_item.byte_second), 32'(want.byte_second));
          compare_field("byte_third", 32'(out_item.byte_third), 32'(want.byte_third));
          compare_field("byte_count", 32'(out_item.byte_count), 32'(want.byte_count));
          compare_field("last_write", 32'(out_item.last_write), 32'(want.last_write));
        end
        beat_no++;
      end
      if (in_valid && in_ready) place_in_frame(in_item);
    end
    pending = frame_writes_q.size();
  end

endmodule

>>> sim/tb.sv
// Top of the shuffle packer testbench: clock, reset, sample and mode stimulus, verdict.
`timescale 1ns / 100ps
module tb;
  import dasp_pkg::*;

  localparam logic REQ_SAMPLES   = ~REQ_CLEAR;
  localparam int   SETTLE_CYCLES = 8;
  localparam int   DRAIN_CYCLES  = 20;
  localparam int   PHASE_ITEMS   = 80;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  logic [1:0] cfg_index;
  logic [0:0] cfg_wdata;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      steady;
  logic      mode_pal, mode_twelve, mode_swap;
  int        fail_count, pending;

  // compression curve knees
  logic [15:0] knees [13] = '{16'h0000, 16'h0400, 16'h0800, 16'h1000, 16'h2000, 16'h4000,
                              16'h8000, 16'hc000, 16'he000, 16'hf000, 16'hf800, 16'hfc00,
                              16'hfe00};
  // {pal, twelve, swap} per random phase
  logic [2:0]  mode_plan [8] = '{3'b000, 3'b111, 3'b010, 3'b101, 3'b001, 3'b110, 3'b100,
                                 3'b011};

  dv_audio_sample_shuffle_packer dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  dasp_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 16);
  end

  function automatic in_item_t make_beat(input logic req, input int n, input logic [15:0] a,
                                         input logic [15:0] b, input logic [15:0] c,
                                         input logic [15:0] d);
    in_item_t it;
    it.req_type     = req;
    it.sample_index = IDX_W'(n);
    it.sample_a     = a;
    it.sample_b     = b;
    it.sample_c     = c;
    it.sample_d     = d;
    return it;
  endfunction

  function automatic logic [15:0] rand_word();
    logic [15:0] v;
    if ($urandom_range(1)) v = 16'($urandom_range(65535));
    else v = knees[$urandom_range(12)] + 16'($urandom_range(2)) - 16'd1;
    // pre-swap so knees survive the byte swap
    if (mode_swap) v = {v[7:0], v[15:8]};
    return v;
  endfunction

  function automatic int rand_index();
    int cap, r;
    cap = (mode_pal ? 54 : 45) * (mode_twelve ? 24 : 36);
    r   = $urandom_range(99);
    if (r < 84)      return $urandom_range(cap - 1);
    else if (r < 94) return $urandom_range(2047, cap);
    else if (r < 97) return cap - 1;
    else             return 0;
  endfunction

  task automatic send_beat(input in_item_t it);
    while (!steady && $urandom_range(99) < 16) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic program_mode(input logic p, input logic t, input logic e);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    // dropped indexes leave no write to wait on
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PAL_MODE;
    cfg_wdata <= p;
    @(negedge clk);
    cfg_index <= CFG_TWELVE_BIT;
    cfg_wdata <= t;
    @(negedge clk);
    cfg_index <= CFG_BIG_ENDIAN;
    cfg_wdata <= e;
    @(negedge clk);
    cfg_we <= 1'b0;
    mode_pal    = p;
    mode_twelve = t;
    mode_swap   = e;
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_PAL_MODE;
    cfg_wdata   = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    steady      = 1'b0;
    mode_pal    = 1'b0;
    mode_twelve = 1'b0;
    mode_swap   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // NTSC, 16-bit, little endian straight out of reset
    send_beat(make_beat(REQ_SAMPLES, 0, 16'h0000, 16'hffff, 16'h1234, 16'habcd));
    send_beat(make_beat(REQ_SAMPLES, 1619, 16'h8001, 16'h7ffe, 16'hffff, 16'h0000));
    send_beat(make_beat(REQ_SAMPLES, 1620, 16'h5555, 16'haaaa, 16'h0f0f, 16'hf0f0));
    send_beat(make_beat(REQ_SAMPLES, 2047, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_beat(make_beat(REQ_CLEAR, 44, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_beat(make_beat(REQ_SAMPLES, 45, 16'h00ff, 16'hff00, 16'h0000, 16'h0000));

    // PAL, 12-bit: every knee of the curve and the value just below it
    program_mode(1'b1, 1'b1, 1'b0);
    send_beat(make_beat(REQ_SAMPLES, 0, 16'hffff, 16'hfe00, 16'hfdff, 16'hfc00));
    send_beat(make_beat(REQ_SAMPLES, 1295, 16'hfbff, 16'hf800, 16'hf7ff, 16'hf000));
    send_beat(make_beat(REQ_SAMPLES, 53, 16'hefff, 16'he000, 16'hdfff, 16'hc000));
    send_beat(make_beat(REQ_SAMPLES, 54, 16'hbfff, 16'h8000, 16'h7fff, 16'h4000));
    send_beat(make_beat(REQ_SAMPLES, 17, 16'h3fff, 16'h2000, 16'h1fff, 16'h1000));
    send_beat(make_beat(REQ_SAMPLES, 18, 16'h0fff, 16'h0800, 16'h07ff, 16'h0400));
    send_beat(make_beat(REQ_SAMPLES, 700, 16'h03ff, 16'h0001, 16'h0000, 16'h0002));
    send_beat(make_beat(REQ_SAMPLES, 1296, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0));
    send_beat(make_beat(REQ_CLEAR, 1000, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0));

    // NTSC, 12-bit, byte swapped
    program_mode(1'b0, 1'b1, 1'b1);
    send_beat(make_beat(REQ_SAMPLES, 1079, 16'h00fe, 16'hfffd, 16'h00f0, 16'h0080));
    send_beat(make_beat(REQ_SAMPLES, 1080, 16'h00fe, 16'hfffd, 16'h00f0, 16'h0080));
    send_beat(make_beat(REQ_CLEAR, 3, 16'hffff, 16'h0000, 16'hffff, 16'h0000));

    // PAL, 16-bit, byte swapped
    program_mode(1'b1, 1'b0, 1'b1);
    send_beat(make_beat(REQ_SAMPLES, 1943, 16'h3412, 16'hff80, 16'hffff, 16'hffff));
    send_beat(make_beat(REQ_SAMPLES, 1944, 16'h3412, 16'hff80, 16'h0000, 16'h0000));
    send_beat(make_beat(REQ_CLEAR, 2, 16'h3412, 16'hff80, 16'h0000, 16'h0000));

    for (int ph = 0; ph < 8; ph++) begin
      program_mode(mode_plan[ph][2], mode_plan[ph][1], mode_plan[ph][0]);
      steady = (ph == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_beat(make_beat(($urandom_range(99) < 12) ? REQ_CLEAR : REQ_SAMPLES,
                            rand_index(), rand_word(), rand_word(), rand_word(),
                            rand_word()));
      end
    end
    steady = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> dv_audio_sample_shuffle_packer.f
hdl/dasp_pkg.sv
hdl/dasp_compress.sv
hdl/dasp_fmt.sv
hdl/dasp_locate.sv
hdl/dasp_out.sv
hdl/dv_audio_sample_shuffle_packer.sv
sim/dasp_checker.sv
sim/tb.sv
